/* rtl/kmau_pkg.sv */
// kmau_pkg: shared widths, codes and types of the k-means assign/update unit
// no dependencies; imported by every module of the block except kmau_div

package kmau_pkg;

   localparam int CHAN_W           = 16;
   localparam int ACTION_W         = 2;
   localparam int INDEX_W          = 4;
   localparam int KIND_W           = 2;
   localparam int LABEL_W          = 4;
   localparam int ICV_W            = 34;
   localparam int CC_W             = 5;
   localparam int CC_RESET         = 16;
   localparam int DEF_MAX_CLUSTERS = 16;
   localparam int DEF_MAX_PIXELS   = 1048576;

   // action codes on the request channel
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PIXEL  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

   // result kinds on the response channel
   localparam logic [KIND_W-1:0] KIND_LABEL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CENTROID = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ICV      = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_PIXEL  = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  index;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
   } item_type;

endpackage

/* rtl/kmeans_assign_update_unit.sv */
// kmeans_assign_update_unit: top level of the k-means assign/update unit
// depends on kmau_pkg, kmau_front, kmau_back (and kmau_div below it)

// One Lloyd k-means pass over RGB pixels in 8.8 fixed point. A load item
// writes a centroid slot, a pixel item returns the label of its nearest
// centroid (lowest index wins ties) and adds it to that cluster's sums,
// and a finish item returns one updated centroid per active cluster, then
// the mean squared distance, and clears the accumulators. Items are worked
// one at a time by the back end. A pixel search runs on the single distance
// unit that compares one centroid per cycle over the n active clusters. A
// finish runs on the shared divider producing one quotient bit per cycle,
// its dividend being 55 bits wide with default parameters. A two-entry
// queue in the front lets requests be taken while the back end works, and
// a response register holds a finished result. Accumulators clear at once
// through per-cluster valid bits, so there is no clearing pass after
// reset; centroid slots must be loaded before use.

module kmeans_assign_update_unit import kmau_pkg::*; #(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_PIXELS   = DEF_MAX_PIXELS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [LABEL_W-1:0]  rsp_label,
   output logic [CHAN_W-1:0]   rsp_new_red,
   output logic [CHAN_W-1:0]   rsp_new_green,
   output logic [CHAN_W-1:0]   rsp_new_blue,
   output logic [ICV_W-1:0]    rsp_icv,
   output logic                rsp_empty_res,
   output logic                rsp_last,
   // cluster count register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CC_W-1:0]     csr_cluster_count
);

   logic [CC_W-1:0] cluster_count_ff, cluster_count_in;
   logic            q_valid;
   item_type        q_item;
   logic            q_pop;

   // register writes are always taken in one transfer
   assign csr_ready = 1'b1;

   always_comb begin
      cluster_count_in = cluster_count_ff;
      if (csr_valid && csr_ready) begin
         cluster_count_in = csr_cluster_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= CC_W'(CC_RESET);
      end else begin
         cluster_count_ff <= cluster_count_in;
      end
   end

   // front: intake, decode and queue
   kmau_front #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_index  (req_index),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back: search, accumulate, update and response register
   kmau_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_PIXELS(MAX_PIXELS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cluster_count (cluster_count_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_label     (rsp_label),
      .rsp_new_red   (rsp_new_red),
      .rsp_new_green (rsp_new_green),
      .rsp_new_blue  (rsp_new_blue),
      .rsp_icv       (rsp_icv),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

endmodule

/* rtl/kmau_div.sv */
// kmau_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; used by kmau_back

module kmau_div #(
   parameter int N = 54,
   parameter int D = 21
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);

   localparam int CW = $clog2(N + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [D-1:0]  dvs_ff, dvs_in;
   logic [D:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[N-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(N);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = D'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/kmau_front.sv */
// kmau_front: request intake, decode of the action and a two-entry item queue
// depends on kmau_pkg

module kmau_front import kmau_pkg::*; #(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   output logic                q_valid,
   output item_type            q_item,
   input  logic                q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep;
   logic       push;
   item_type   dec;

   // decode; unused action and loads beyond the store are dropped here
   always_comb begin
      keep      = 1'b0;
      dec.op    = OP_LOAD;
      dec.index = req_index;
      dec.red   = req_red;
      dec.green = req_green;
      dec.blue  = req_blue;
      case (req_action)
         ACT_LOAD: begin
            dec.op = OP_LOAD;
            keep   = (32'(req_index) < MAX_CLUSTERS);
         end
         ACT_PIXEL: begin
            dec.op = OP_PIXEL;
            keep   = 1'b1;
         end
         ACT_FINISH: begin
            dec.op = OP_FINISH;
            keep   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* rtl/kmau_back.sv */
// kmau_back: sequencer with centroid and accumulator stores, distance search,
// update division and the response register; depends on kmau_pkg, kmau_div

module kmau_back import kmau_pkg::*; #(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_PIXELS   = DEF_MAX_PIXELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CC_W-1:0]     cluster_count,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [LABEL_W-1:0]  rsp_label,
   output logic [CHAN_W-1:0]   rsp_new_red,
   output logic [CHAN_W-1:0]   rsp_new_green,
   output logic [CHAN_W-1:0]   rsp_new_blue,
   output logic [ICV_W-1:0]    rsp_icv,
   output logic                rsp_empty_res,
   output logic                rsp_last
);

   localparam int CW     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int NW     = $clog2(MAX_CLUSTERS + 1);
   localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W  = CHAN_W + PIX_W;
   localparam int SQ_W   = 2 * CHAN_W;
   localparam int D_W    = 2 * CHAN_W + 2;
   localparam int DIST_W = D_W + PIX_W;
   localparam int ACC_W  = 3 * SUM_W + PIX_W;
   localparam int CENT_W = 3 * CHAN_W;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_SEARCH    = 14'b00000000000010,
      ST_ACC_RD    = 14'b00000000000100,
      ST_ACC_WR    = 14'b00000000001000,
      ST_LABEL     = 14'b00000000010000,
      ST_FIN_RD    = 14'b00000000100000,
      ST_FIN_CHK   = 14'b00000001000000,
      ST_FIN_START = 14'b00000010000000,
      ST_FIN_DIV   = 14'b00000100000000,
      ST_FIN_WR    = 14'b00001000000000,
      ST_FIN_EMIT  = 14'b00010000000000,
      ST_ICV_START = 14'b00100000000000,
      ST_ICV_DIV   = 14'b01000000000000,
      ST_ICV_EMIT  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // stores
   logic [CENT_W-1:0] cent_mem [MAX_CLUSTERS];
   logic [ACC_W-1:0]  acc_mem  [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] acc_vld_ff, acc_vld_in;
   logic [CENT_W-1:0] cent_rd_ff;
   logic [ACC_W-1:0]  acc_rd_ff;
   logic              acc_rv_ff;
   logic [CW-1:0]     cent_raddr, acc_raddr;
   logic              cent_we, acc_we;
   logic [CW-1:0]     cent_waddr;
   logic [CENT_W-1:0] cent_wdata;
   logic [ACC_W-1:0]  acc_wdata;

   // current pixel and search pipeline
   logic [CHAN_W-1:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic              load_pix;
   logic [NW-1:0]     n_act, n_last;
   logic [NW-1:0]     issue_ff, issue_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [NW-1:0]     rd_idx_ff;
   logic              sq_vld_ff;
   logic [NW-1:0]     sq_idx_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [CHAN_W-1:0] dr, dg, db;
   logic [D_W-1:0]    dsum;
   logic [NW-1:0]     best_ff, best_in;
   logic [D_W-1:0]    best_d_ff, best_d_in;

   // pass totals
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [PIX_W-1:0]  seen_ff, seen_in;

   // finish sequencing
   logic [NW-1:0]     fk_ff, fk_in;
   logic [1:0]        ch_ff, ch_in;
   logic [CHAN_W-1:0] res_r_ff, res_g_ff, res_b_ff;
   logic [CHAN_W-1:0] res_r_in, res_g_in, res_b_in;
   logic              res_empty_ff, res_empty_in;
   logic [ICV_W-1:0]  icv_res_ff, icv_res_in;

   // accumulator entry as read
   logic [ACC_W-1:0]  acc_cur;
   logic [SUM_W-1:0]  cur_r, cur_g, cur_b;
   logic [PIX_W-1:0]  cur_cnt;

   // divider
   logic              div_start, div_done;
   logic [DIST_W-1:0] div_dividend, div_quo;
   logic [PIX_W-1:0]  div_divisor;

   // response register
   logic               out_free, out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  o_kind, rsp_kind_ff;
   logic [LABEL_W-1:0] o_label, rsp_label_ff;
   logic [CHAN_W-1:0]  o_r, o_g, o_b, rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic [ICV_W-1:0]   o_icv, rsp_icv_ff;
   logic               o_empty, rsp_empty_ff, o_last, rsp_last_ff;

   kmau_div #(.N(DIST_W), .D(PIX_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // active cluster count, clamped to one..MAX_CLUSTERS
   always_comb begin
      if (cluster_count == '0) begin
         n_act = NW'(1);
      end else if (32'(cluster_count) > MAX_CLUSTERS) begin
         n_act = NW'(MAX_CLUSTERS);
      end else begin
         n_act = NW'(cluster_count);
      end
      n_last = n_act - 1'b1;
   end

   assign acc_cur = acc_rv_ff ? acc_rd_ff : '0;
   assign cur_r   = acc_cur[ACC_W-1 -: SUM_W];
   assign cur_g   = acc_cur[ACC_W-1-SUM_W -: SUM_W];
   assign cur_b   = acc_cur[PIX_W+SUM_W-1 -: SUM_W];
   assign cur_cnt = acc_cur[PIX_W-1:0];

   // distance datapath
   always_comb begin
      dr = (pix_r_ff > cent_rd_ff[CENT_W-1 -: CHAN_W]) ?
           pix_r_ff - cent_rd_ff[CENT_W-1 -: CHAN_W] :
           cent_rd_ff[CENT_W-1 -: CHAN_W] - pix_r_ff;
      dg = (pix_g_ff > cent_rd_ff[2*CHAN_W-1 -: CHAN_W]) ?
           pix_g_ff - cent_rd_ff[2*CHAN_W-1 -: CHAN_W] :
           cent_rd_ff[2*CHAN_W-1 -: CHAN_W] - pix_g_ff;
      db = (pix_b_ff > cent_rd_ff[CHAN_W-1:0]) ?
           pix_b_ff - cent_rd_ff[CHAN_W-1:0] :
           cent_rd_ff[CHAN_W-1:0] - pix_b_ff;
      dsum = D_W'(sq_r_ff) + D_W'(sq_g_ff) + D_W'(sq_b_ff);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      load_pix     = 1'b0;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      dist_in      = dist_ff;
      seen_in      = seen_ff;
      acc_vld_in   = acc_vld_ff;
      fk_in        = fk_ff;
      ch_in        = ch_ff;
      res_r_in     = res_r_ff;
      res_g_in     = res_g_ff;
      res_b_in     = res_b_ff;
      res_empty_in = res_empty_ff;
      icv_res_in   = icv_res_ff;
      cent_raddr   = fk_ff[CW-1:0];
      acc_raddr    = fk_ff[CW-1:0];
      cent_we      = 1'b0;
      cent_waddr   = q_item.index[CW-1:0];
      cent_wdata   = {q_item.red, q_item.green, q_item.blue};
      acc_we       = 1'b0;
      acc_wdata    = {cur_r + SUM_W'(pix_r_ff), cur_g + SUM_W'(pix_g_ff),
                      cur_b + SUM_W'(pix_b_ff), cur_cnt + 1'b1};
      div_start    = 1'b0;
      div_dividend = dist_ff;
      div_divisor  = seen_ff;
      out_load     = 1'b0;
      o_kind       = KIND_LABEL;
      o_label      = LABEL_W'(best_ff);
      o_r          = '0;
      o_g          = '0;
      o_b          = '0;
      o_icv        = '0;
      o_empty      = 1'b0;
      o_last       = 1'b0;

      // compare stage runs whenever a squared distance is ready
      if (sq_vld_ff && ((sq_idx_ff == '0) || (dsum < best_d_ff))) begin
         best_in   = sq_idx_ff;
         best_d_in = dsum;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_LOAD: cent_we = 1'b1;
                  OP_PIXEL: begin
                     load_pix = 1'b1;
                     issue_in = '0;
                     state_in = ST_SEARCH;
                  end
                  OP_FINISH: begin
                     fk_in    = '0;
                     state_in = ST_FIN_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            cent_raddr = issue_ff[CW-1:0];
            if (issue_ff < n_act) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + 1'b1;
            end
            if (sq_vld_ff && (sq_idx_ff == n_last)) begin
               state_in = ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            acc_raddr = best_ff[CW-1:0];
            state_in  = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            acc_raddr = best_ff[CW-1:0];
            if (seen_ff < PIX_W'(MAX_PIXELS)) begin
               acc_we                      = 1'b1;
               acc_vld_in[best_ff[CW-1:0]] = 1'b1;
               dist_in                     = dist_ff + DIST_W'(best_d_ff);
               seen_in                     = seen_ff + 1'b1;
            end
            state_in = ST_LABEL;
         end
         ST_LABEL: begin
            if (out_free) begin
               out_load = 1'b1;
               o_kind   = KIND_LABEL;
               o_label  = LABEL_W'(best_ff);
               o_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FIN_RD: state_in = ST_FIN_CHK;
         ST_FIN_CHK: begin
            if (cur_cnt == '0) begin
               res_r_in     = cent_rd_ff[CENT_W-1 -: CHAN_W];
               res_g_in     = cent_rd_ff[2*CHAN_W-1 -: CHAN_W];
               res_b_in     = cent_rd_ff[CHAN_W-1:0];
               res_empty_in = 1'b1;
               state_in     = ST_FIN_EMIT;
            end else begin
               res_empty_in = 1'b0;
               ch_in        = CH_RED;
               state_in     = ST_FIN_START;
            end
         end
         ST_FIN_START: begin
            div_start   = 1'b1;
            div_divisor = cur_cnt;
            case (ch_ff)
               CH_RED:   div_dividend = DIST_W'(cur_r);
               CH_GREEN: div_dividend = DIST_W'(cur_g);
               default:  div_dividend = DIST_W'(cur_b);
            endcase
            state_in = ST_FIN_DIV;
         end
         ST_FIN_DIV: begin
            if (div_done) begin
               case (ch_ff)
                  CH_RED: begin
                     res_r_in = div_quo[CHAN_W-1:0];
                     ch_in    = CH_GREEN;
                     state_in = ST_FIN_START;
                  end
                  CH_GREEN: begin
                     res_g_in = div_quo[CHAN_W-1:0];
                     ch_in    = CH_BLUE;
                     state_in = ST_FIN_START;
                  end
                  default: begin
                     res_b_in = div_quo[CHAN_W-1:0];
                     state_in = ST_FIN_WR;
                  end
               endcase
            end
         end
         ST_FIN_WR: begin
            cent_we    = 1'b1;
            cent_waddr = fk_ff[CW-1:0];
            cent_wdata = {res_r_ff, res_g_ff, res_b_ff};
            state_in   = ST_FIN_EMIT;
         end
         ST_FIN_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               o_kind   = KIND_CENTROID;
               o_label  = LABEL_W'(fk_ff);
               o_r      = res_r_ff;
               o_g      = res_g_ff;
               o_b      = res_b_ff;
               o_empty  = res_empty_ff;
               if (fk_ff == n_last) begin
                  state_in = ST_ICV_START;
               end else begin
                  fk_in    = fk_ff + 1'b1;
                  state_in = ST_FIN_RD;
               end
            end
         end
         ST_ICV_START: begin
            if (seen_ff == '0) begin
               icv_res_in = '0;
               state_in   = ST_ICV_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_ICV_DIV;
            end
         end
         ST_ICV_DIV: begin
            if (div_done) begin
               icv_res_in = div_quo[ICV_W-1:0];
               state_in   = ST_ICV_EMIT;
            end
         end
         ST_ICV_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               o_kind     = KIND_ICV;
               o_label    = '0;
               o_icv      = icv_res_ff;
               o_last     = 1'b1;
               acc_vld_in = '0;
               dist_in    = '0;
               seen_in    = '0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         acc_vld_ff   <= '0;
         dist_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         sq_vld_ff    <= rd_vld_ff;
         acc_vld_ff   <= acc_vld_in;
         dist_ff      <= dist_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      rd_idx_ff    <= issue_ff;
      sq_idx_ff    <= rd_idx_ff;
      sq_r_ff      <= dr * dr;
      sq_g_ff      <= dg * dg;
      sq_b_ff      <= db * db;
      best_ff      <= best_in;
      best_d_ff    <= best_d_in;
      fk_ff        <= fk_in;
      ch_ff        <= ch_in;
      res_r_ff     <= res_r_in;
      res_g_ff     <= res_g_in;
      res_b_ff     <= res_b_in;
      res_empty_ff <= res_empty_in;
      icv_res_ff   <= icv_res_in;
      if (load_pix) begin
         pix_r_ff <= q_item.red;
         pix_g_ff <= q_item.green;
         pix_b_ff <= q_item.blue;
      end
      if (out_load) begin
         rsp_kind_ff  <= o_kind;
         rsp_label_ff <= o_label;
         rsp_r_ff     <= o_r;
         rsp_g_ff     <= o_g;
         rsp_b_ff     <= o_b;
         rsp_icv_ff   <= o_icv;
         rsp_empty_ff <= o_empty;
         rsp_last_ff  <= o_last;
      end
   end

   // centroid store
   always_ff @(posedge clock) begin
      if (cent_we) begin
         cent_mem[cent_waddr] <= cent_wdata;
      end
      cent_rd_ff <= cent_mem[cent_raddr];
   end

   // accumulator store, entries not marked valid read as zero
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[best_ff[CW-1:0]] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
      acc_rv_ff <= acc_vld_ff[acc_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_label     = rsp_label_ff;
   assign rsp_new_red   = rsp_r_ff;
   assign rsp_new_green = rsp_g_ff;
   assign rsp_new_blue  = rsp_b_ff;
   assign rsp_icv       = rsp_icv_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
